[hw/rtl/cdstf_pkg.sv]
// Shared types and constants of the codeword bit destuffer.
package cdstf_pkg;

   localparam int unsigned BYTE_BITS = 8;
   localparam int unsigned STUFF_RUN = 5;
   localparam logic [2:0] END_FLAG_HELD = 3'd6;
   localparam logic [2:0] LAST_BIT_POS = 3'd7;

   // Configuration register indexes.
   localparam logic CSR_CODEWORD_LEN = 1'b0;
   localparam logic CSR_INFO_LEN = 1'b1;

   typedef enum logic [1:0] {
      ST_RUNNING   = 2'd0,
      ST_OK        = 2'd1,
      ST_STUFF_ERR = 2'd2,
      ST_NO_END    = 2'd3
   } cdstf_status_type;

   // Bit-level destuffing state carried from one byte to the next.
   typedef struct packed {
      logic [2:0] ones_run;
      logic       drop_next_zero;
      logic [7:0] partial_byte;
      logic [2:0] partial_bits;
   } cdstf_bits_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             byte_valid;
      cdstf_status_type status;
      logic [7:0]       out_count;
   } cdstf_result_type;

endpackage

[hw/rtl/cdstf_walk.sv]
// Combinational walk of one codeword byte through the destuffing rules.
module cdstf_walk (
   input  cdstf_pkg::cdstf_bits_type   bits_cur,
   input  logic [7:0]                  emitted_cur,
   input  logic [7:0]                  bytes_seen_cur,
   input  logic [7:0]                  code_byte,
   input  logic [7:0]                  codeword_len,
   input  logic [7:0]                  info_len,
   output cdstf_pkg::cdstf_bits_type   bits_nxt,
   output logic [7:0]                  bytes_seen_nxt,
   output cdstf_pkg::cdstf_result_type result
);
   import cdstf_pkg::*;

   always_comb begin
      cdstf_bits_type   st;
      logic [7:0]       cnt;
      logic [7:0]       seen;
      logic [7:0]       obyte;
      logic             valid;
      logic             done;
      logic             bit_v;
      cdstf_status_type status;

      st = bits_cur;
      cnt = emitted_cur;
      seen = bytes_seen_cur;
      obyte = '0;
      valid = 1'b0;
      done = 1'b0;
      bit_v = 1'b0;
      status = ST_RUNNING;

      if (bytes_seen_cur >= codeword_len) begin
         status = ST_NO_END;
      end else begin
         for (int i = 0; i < BYTE_BITS; i++) begin
            if (!done) begin
               bit_v = code_byte[i];
               if (st.drop_next_zero) begin
                  // Bit after five ones: a zero is stuffing, a one is a flag.
                  if (!bit_v) begin
                     st.drop_next_zero = 1'b0;
                  end else begin
                     status = (st.partial_bits == END_FLAG_HELD) ? ST_OK : ST_STUFF_ERR;
                     done = 1'b1;
                  end
               end else begin
                  if (bit_v) begin
                     if (st.ones_run == 3'(STUFF_RUN - 1)) begin
                        st.drop_next_zero = 1'b1;
                        st.ones_run = '0;
                     end else begin
                        st.ones_run = st.ones_run + 3'd1;
                     end
                  end else begin
                     st.ones_run = '0;
                  end
                  st.partial_byte[st.partial_bits] = bit_v;
                  if (st.partial_bits == LAST_BIT_POS) begin
                     valid = 1'b1;
                     obyte = st.partial_byte;
                     cnt = cnt + 8'd1;
                     st.partial_byte = '0;
                     st.partial_bits = '0;
                     if (cnt >= info_len) begin
                        status = ST_OK;
                        done = 1'b1;
                     end
                  end else begin
                     st.partial_bits = st.partial_bits + 3'd1;
                  end
               end
            end
         end
         seen = bytes_seen_cur + 8'd1;
         if (status == ST_RUNNING && seen >= codeword_len) begin
            status = ST_NO_END;
         end
      end

      bits_nxt = st;
      bytes_seen_nxt = seen;
      result.out_byte = obyte;
      result.byte_valid = valid;
      result.status = status;
      result.out_count = cnt;
   end

endmodule

[hw/rtl/codeword_bit_destuffer.sv]
// Top level of the codeword bit destuffer: request stage, frame state, response register.
//
// Usage: codeword bytes enter on the req_ channel, one request per byte, with
// req_frame_start high on the opening flag byte. The flag byte opens a frame
// and clears all destuffing state; it produces no response. Each later byte
// of an open frame produces exactly one response on the rsp_ channel carrying
// the destuffed byte completed in it (if any), the frame status and the count
// of bytes emitted so far. Bytes outside an open frame produce no response.
// Each request taken is registered in the request stage, walked through the
// eight bit steps and its response is registered in the response register.
// Throughput is one byte per cycle while rsp_stall is low, set by the single
// eight-step combinational walk between the request and response registers.
// When the receiver stalls, the response register holds, the request stage
// holds its byte and req_stall rises only while that stage is occupied, so
// one more byte is still taken. Reset is synchronous: it empties both stages,
// closes any frame and restores codeword_len to 255 and info_len to 239. The user
// must write configuration through csr_ while idle; the block does not enforce it.
module codeword_bit_destuffer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_frame_start,
   input  logic [7:0] req_code_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_out_count,
   input  logic       csr_write,
   input  logic       csr_index,
   input  logic [7:0] csr_data
);
   import cdstf_pkg::*;

   // Configuration registers.
   logic [7:0] codeword_len_ff, codeword_len_in;
   logic [7:0] info_len_ff, info_len_in;

   // Request stage.
   logic       req_hold_ff, req_hold_in;
   logic       start_ff;
   logic [7:0] code_ff;

   // Frame state.
   logic           frame_active_ff, frame_active_in;
   logic [7:0]     bytes_seen_ff, bytes_seen_in;
   logic [7:0]     emitted_ff, emitted_in;
   cdstf_bits_type bits_ff, bits_in;

   // Response register.
   logic             rsp_valid_ff, rsp_valid_in;
   cdstf_result_type rsp_ff;

   cdstf_bits_type   walk_bits;
   logic [7:0]       walk_seen;
   cdstf_result_type walk_result;

   logic advance;
   logic req_take;
   logic process;
   logic emit;

   // The request stage moves on whenever the response register is free or drains.
   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = req_hold_ff && !advance;
   assign req_take = req_valid && !req_stall;
   assign process  = req_hold_ff && advance;
   assign emit     = process && !start_ff && frame_active_ff;

   cdstf_walk u_walk (
      .bits_cur       (bits_ff),
      .emitted_cur    (emitted_ff),
      .bytes_seen_cur (bytes_seen_ff),
      .code_byte      (code_ff),
      .codeword_len   (codeword_len_ff),
      .info_len       (info_len_ff),
      .bits_nxt       (walk_bits),
      .bytes_seen_nxt (walk_seen),
      .result         (walk_result)
   );

   always_comb begin
      codeword_len_in = codeword_len_ff;
      info_len_in = info_len_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_CODEWORD_LEN: codeword_len_in = csr_data;
            CSR_INFO_LEN:     info_len_in = csr_data;
            default:          ;
         endcase
      end
   end

   always_comb begin
      req_hold_in = req_hold_ff;
      if (req_take) begin
         req_hold_in = 1'b1;
      end else if (advance) begin
         req_hold_in = 1'b0;
      end
   end

   // A flag byte restarts the frame; a data byte of an open frame steps it,
   // and any final status closes it.
   always_comb begin
      frame_active_in = frame_active_ff;
      bytes_seen_in = bytes_seen_ff;
      emitted_in = emitted_ff;
      bits_in = bits_ff;
      if (process && start_ff) begin
         frame_active_in = 1'b1;
         bytes_seen_in = 8'd1;
         emitted_in = '0;
         bits_in = '0;
      end else if (emit) begin
         bytes_seen_in = walk_seen;
         emitted_in = walk_result.out_count;
         bits_in = walk_bits;
         frame_active_in = (walk_result.status == ST_RUNNING);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codeword_len_ff <= 8'd255;
         info_len_ff <= 8'd239;
         req_hold_ff <= 1'b0;
         frame_active_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         codeword_len_ff <= codeword_len_in;
         info_len_ff <= info_len_in;
         req_hold_ff <= req_hold_in;
         frame_active_ff <= frame_active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_seen_ff <= bytes_seen_in;
      emitted_ff <= emitted_in;
      bits_ff <= bits_in;
      if (req_take) begin
         start_ff <= req_frame_start;
         code_ff <= req_code_byte;
      end
      if (emit) begin
         rsp_ff <= walk_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = rsp_ff.out_byte;
   assign rsp_byte_valid = rsp_ff.byte_valid;
   assign rsp_status = rsp_ff.status;
   assign rsp_out_count = rsp_ff.out_count;

endmodule
